>>> rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned CmdW         = 3;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned DepthDefault = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [DataW-1:0] value;
  } op_t;

  // head of the command queue, as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } cmdq_head_t;

endpackage

>>> rtl/cdq_front.sv
module cdq_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic [cdq_pkg::CmdW-1:0]        command_i,
  input  logic signed [cdq_pkg::DataW-1:0] value_i,
  output logic                            busy,
  output cdq_pkg::cmdq_head_t             head_o,
  input  logic                            take_i
);
  import cdq_pkg::*;

  op_t        slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       cmd_ok;
  logic       push;
  logic       pop;

  // drop unused command codes here; they never reach the back end
  assign cmd_ok = command_i inside {CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_POP_FRONT,
                                    CMD_POP_BACK, CMD_LIST};

  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy && cmd_ok;
  assign pop  = take_i && (cnt_q != 2'd0);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.op    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{cmd: cmd_e'(command_i), value: value_i};
    end
  end

endmodule

>>> rtl/cdq_back.sv
module cdq_back #(
  parameter int unsigned DEPTH = cdq_pkg::DepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cdq_pkg::cmdq_head_t               head_i,
  output logic                              take_o,
  output logic                              strobe_o,
  output logic signed [cdq_pkg::DataW-1:0]  value_res_o,
  output logic [cdq_pkg::StatusW-1:0]       status_o,
  output logic                              last_o
);
  import cdq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW:0]   DepthS = (CW+1)'(DEPTH);
  localparam logic [AW-1:0] LastA  = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_LIST = 3'b100
  } state_e;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == LastA) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
    return (a == '0) ? LastA : a - 1'b1;
  endfunction

  // offset is always below DEPTH, so one subtract folds the sum back
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] h,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(off);
    if (sum >= DepthS) sum = sum - DepthS;
    return sum[AW-1:0];
  endfunction

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rdata_q;

  state_e           state_q, state_d;
  logic [AW-1:0]    hd_q, hd_d;
  logic [CW-1:0]    occ_q, occ_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    idx_q, idx_d;

  logic             strobe_q, strobe_d;
  logic [DataW-1:0] value_q, value_d;
  status_e          status_q, status_d;
  logic             last_q, last_d;

  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             occ_full, occ_empty, list_end;

  assign occ_full  = (occ_q == DepthC);
  assign occ_empty = (occ_q == '0);
  assign list_end  = (idx_q == occ_q - 1'b1);

  always_comb begin
    state_d  = state_q;
    hd_d     = hd_q;
    occ_d    = occ_q;
    ptr_d    = ptr_q;
    idx_d    = idx_q;
    take_o   = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = hd_q;
    rd_addr  = hd_q;
    strobe_d = 1'b0;
    value_d  = '0;
    status_d = ST_OK;
    last_d   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          take_o = 1'b1;
          case (head_i.op.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              strobe_d = 1'b1;
              if (occ_full) begin
                status_d = ST_FULL;
              end else begin
                wr_en = 1'b1;
                occ_d = occ_q + 1'b1;
                if (head_i.op.cmd == CMD_PUSH_FRONT) begin
                  wr_addr = wrap_dec(hd_q);
                  hd_d    = wrap_dec(hd_q);
                end else begin
                  wr_addr = ring_add(hd_q, occ_q);
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (occ_empty) begin
                strobe_d = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                occ_d   = occ_q - 1'b1;
                state_d = S_POP;
                if (head_i.op.cmd == CMD_POP_FRONT) begin
                  rd_addr = hd_q;
                  hd_d    = wrap_inc(hd_q);
                end else begin
                  rd_addr = ring_add(hd_q, occ_q - 1'b1);
                end
              end
            end
            CMD_LIST: begin
              if (occ_empty) begin
                strobe_d = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = hd_q;
                ptr_d   = wrap_inc(hd_q);
                idx_d   = '0;
                state_d = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        strobe_d = 1'b1;
        value_d  = rdata_q;
        state_d  = S_IDLE;
      end
      S_LIST: begin
        // emit the word fetched last cycle, fetch the next one
        strobe_d = 1'b1;
        value_d  = rdata_q;
        last_d   = list_end;
        rd_en    = 1'b1;
        rd_addr  = ptr_q;
        ptr_d    = wrap_inc(ptr_q);
        idx_d    = idx_q + 1'b1;
        if (list_end) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      hd_q     <= '0;
      occ_q    <= '0;
      ptr_q    <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      hd_q     <= hd_d;
      occ_q    <= occ_d;
      ptr_q    <= ptr_d;
      idx_q    <= idx_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= head_i.op.value;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  assign strobe_o    = strobe_q;
  assign value_res_o = value_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

>>> rtl/circular_deque_unit.sv
// channel  | handshake          | ports
// ---------+--------------------+-----------------------------------------
// command  | start && !busy     | command_i, value_i
// result   | strobe_o (1 cycle) | value_res_o, status_o, last_o
//
// A command enters a two-word command queue; busy is high while it is full.
// The back end takes one command per cycle for a push or a refused command;
// a pop holds it for one memory read, a list until every stored word is out.
// Each result is registered onto the result ports the cycle after it is made.
// Reset clears the queue, the head index and the occupancy; the word store
// is not cleared. The receiver cannot stall: every strobe is one word taken.
module circular_deque_unit #(
  parameter int unsigned DEPTH = cdq_pkg::DepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [cdq_pkg::CmdW-1:0]          command_i,
  input  logic signed [cdq_pkg::DataW-1:0]  value_i,
  output logic                              strobe_o,
  output logic signed [cdq_pkg::DataW-1:0]  value_res_o,
  output logic [cdq_pkg::StatusW-1:0]       status_o,
  output logic                              last_o
);
  import cdq_pkg::*;

  cmdq_head_t qhead;
  logic       take;

  cdq_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .command_i(command_i),
    .value_i  (value_i),
    .busy     (busy),
    .head_o   (qhead),
    .take_i   (take)
  );

  cdq_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (qhead),
    .take_o     (take),
    .strobe_o   (strobe_o),
    .value_res_o(value_res_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

endmodule
